/* sv/vdh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdh_pkg
// Shared types and constants for the V-disparity histogram core.
// ----------------------------------------------------------------------------
package vdh_pkg;

    localparam int ACT_W        = 2;
    localparam int ROW_W        = 9;
    localparam int BIN_W        = 8;
    localparam int COUNT_W      = 8;
    localparam int ROW_EXT_W    = 13;   // holds any row limit up to 4096
    localparam int DEF_MAX_ROWS = 512;

    localparam logic [ACT_W-1:0] ACT_ACCUM = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RDCLR = 2'd2;

    localparam logic [BIN_W-1:0] DISP_SKIP_LO = 8'd0;
    localparam logic [BIN_W-1:0] DISP_SKIP_HI = 8'd255;

    // work queued for the back end
    typedef enum logic [1:0] {
        OP_INC,     // add one to the bin
        OP_READ,    // return the bin
        OP_RDCLR,   // return the bin and zero it
        OP_ZERO     // row out of range: return zero, touch nothing
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ROW_W-1:0] row;
        logic [BIN_W-1:0] bin;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

/* sv/v_disparity_histogram_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v_disparity_histogram_core
// Row-wise disparity (V-disparity) histogram: per-row 8-bit bin counters
// with accumulate, read and read-and-clear requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  s_      | in  | s_valid / s_ready  | s_action[1:0] s_row[8:0] s_disparity[7:0]
//  m_      | out | m_valid / m_ready  | m_count[7:0]
//
//  Throughput: one request per cycle sustained while m_ready is high; set by
//    the read-modify-write pipeline on the histogram memory (one read and one
//    write port), with forwarding between back-to-back requests to one bin.
//  Read path: a read request passes the queue, then the memory read stage,
//    then the output register, before m_valid rises.
//  Reset: after aresetn the memory is swept to zero, one entry per cycle,
//    over all MAX_ROWS*256 entries (131072 at the default); s_ready stays low meanwhile.
//  Stalls: a two-entry queue and the output register decouple both sides.
// ----------------------------------------------------------------------------
module v_disparity_histogram_core #(
    parameter int MAX_ROWS = vdh_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vdh_pkg::ACT_W-1:0]   s_action,
    input  logic [vdh_pkg::ROW_W-1:0]   s_row,
    input  logic [vdh_pkg::BIN_W-1:0]   s_disparity,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vdh_pkg::COUNT_W-1:0] m_count
);
    import vdh_pkg::*;

    q_head_t            q_head;
    logic               q_pop;
    logic               init_done;
    logic               res_valid, res_ready;
    logic [COUNT_W-1:0] res_count;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg;
    logic               load;

    // front: classify, drop no-op requests, queue the rest
    vdh_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init_done   (init_done),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_row       (s_row),
        .s_disparity (s_disparity),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    // back: memory pipeline and clearing sweep
    vdh_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_count (res_count)
    );

    // the register accepts a new result whenever it is empty or draining
    assign res_ready = !m_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_count_reg <= res_count;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_count = m_count_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !load)
        else $error("pending result overwritten");

endmodule

/* sv/vdh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdh_front
// Request intake: classifies requests, drops no-ops, queues the rest.
// ----------------------------------------------------------------------------
module vdh_front #(
    parameter int MAX_ROWS = vdh_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        init_done,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vdh_pkg::ACT_W-1:0]   s_action,
    input  logic [vdh_pkg::ROW_W-1:0]   s_row,
    input  logic [vdh_pkg::BIN_W-1:0]   s_disparity,
    output vdh_pkg::q_head_t            q_head,
    input  logic                        q_pop
);
    import vdh_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

    cmd_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    logic in_range, keep, push, pop;
    cmd_t cls;

    always_comb begin
        in_range = {{(ROW_EXT_W-ROW_W){1'b0}}, s_row} < ROW_EXT_W'(MAX_ROWS);
        cls.row  = s_row;
        cls.bin  = s_disparity;
        cls.op   = OP_ZERO;
        keep     = 1'b0;
        case (s_action)
            ACT_ACCUM: begin
                cls.op = OP_INC;
                keep   = in_range && (s_disparity != DISP_SKIP_LO)
                                  && (s_disparity != DISP_SKIP_HI);
            end
            ACT_READ: begin
                cls.op = in_range ? OP_READ : OP_ZERO;
                keep   = 1'b1;
            end
            ACT_RDCLR: begin
                cls.op = in_range ? OP_RDCLR : OP_ZERO;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready      = init_done && (cnt_reg != FULL_CNT);
    assign push         = s_valid && s_ready && keep;
    assign q_head.valid = (cnt_reg != '0);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];
    assign pop          = q_head.valid && q_pop;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == FULL_CNT) && !pop |=> cnt_reg == FULL_CNT)
        else $error("full queue lost an entry");

endmodule

/* sv/vdh_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdh_back
// Histogram memory with read-modify-write pipeline, forwarding and the
// post-reset clearing sweep.
// ----------------------------------------------------------------------------
module vdh_back #(
    parameter int MAX_ROWS = vdh_pkg::DEF_MAX_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          init_done,
    input  vdh_pkg::q_head_t              q_head,
    output logic                          q_pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [vdh_pkg::COUNT_W-1:0]   res_count
);
    import vdh_pkg::*;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW     = ROW_AW + BIN_W;
    localparam int DEPTH  = MAX_ROWS * (2 ** BIN_W);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [COUNT_W-1:0] mem [DEPTH];

    // clearing sweep
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // stage B (modify/write)
    logic               b_valid_reg, b_valid_next;
    op_t                b_op_reg;
    logic [AW-1:0]      b_addr_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               fwd_hit_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic [ROW_EXT_W-1:0] row_ext;
    logic [AW-1:0]        issue_addr;
    logic                 issue, b_fire, b_has_res, b_wr_en;
    logic [COUNT_W-1:0]   old_val, b_wr_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [COUNT_W-1:0]   mem_wdata;

    assign init_done  = !clearing_reg;
    assign row_ext    = {{(ROW_EXT_W-ROW_W){1'b0}}, q_head.cmd.row};
    assign issue_addr = {row_ext[ROW_AW-1:0], q_head.cmd.bin};

    always_comb begin
        old_val   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        b_has_res = (b_op_reg != OP_INC);
        b_fire    = b_valid_reg && (!b_has_res || res_ready);
        b_wr_en   = b_fire && ((b_op_reg == OP_INC) || (b_op_reg == OP_RDCLR));
        b_wr_data = (b_op_reg == OP_INC) ? old_val + COUNT_W'(1) : '0;
        issue     = q_head.valid && !clearing_reg && (!b_valid_reg || b_fire);
        q_pop     = issue;
        res_valid = b_valid_reg && b_has_res;
        res_count = (b_op_reg == OP_ZERO) ? '0 : old_val;

        b_valid_next = issue ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);

        clr_addr_next = clr_addr_reg + AW'(1);
        clearing_next = clearing_reg && (clr_addr_reg != LAST_ADDR);

        mem_we    = clearing_reg ? 1'b1 : b_wr_en;
        mem_waddr = clearing_reg ? clr_addr_reg : b_addr_reg;
        mem_wdata = clearing_reg ? '0 : b_wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_next;
            end
            b_valid_reg <= b_valid_next;
        end
    end

    // stage B payload, forward from the write that lands with this read
    always_ff @(posedge aclk) begin
        if (issue) begin
            b_op_reg     <= q_head.cmd.op;
            b_addr_reg   <= issue_addr;
            fwd_hit_reg  <= b_wr_en && (b_addr_reg == issue_addr);
            fwd_data_reg <= b_wr_data;
        end
    end

    // memory: read returns pre-write data on a same-cycle collision
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            rd_data_reg <= mem[issue_addr];
        end
    end

    a_no_issue_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !issue && !b_valid_reg)
        else $error("request issued during clearing sweep");

    a_clr_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> $past(clr_addr_reg) == LAST_ADDR)
        else $error("clearing sweep ended early");

endmodule
